// ===== sv/upd_pkg.sv =====
// Shared types and character codes for the URL percent decoder.
`default_nettype none

package upd_pkg;

  localparam int WIN_N  = 6;
  localparam int HELD_N = 5;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_UP_U  = 8'h55;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       msg_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_last;
  } out_t;

  typedef struct packed {
    logic [2:0] used;
    logic       two;
    logic [7:0] b0;
    logic [7:0] b1;
  } head_t;

  typedef struct packed {
    logic [2:0]                 cnt;
    logic [WIN_N-1:0][7:0]      bytes;
    logic [2:0]                 held_cnt;
    logic [HELD_N-1:0][7:0]     held;
  } dec_res_t;

  typedef struct packed {
    logic [2:0]            cnt;
    logic [WIN_N-1:0][7:0] bytes;
    logic                  fin;
  } ob_load_t;

endpackage

`default_nettype wire

// ===== sv/upd_decode.sv =====
// Window decode: held bytes plus the new byte into result bytes and new held bytes.
`default_nettype none

module upd_decode (
  input  logic [upd_pkg::HELD_N-1:0][7:0] held,
  input  logic [2:0]                      held_cnt,
  input  upd_pkg::in_t                    req,
  output upd_pkg::dec_res_t               res
);
  import upd_pkg::*;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    case (c) inside
      [8'h30:8'h39]: v = 4'(c - 8'h30);
      [8'h41:8'h46]: v = 4'(c - 8'h41 + 8'd10);
      [8'h61:8'h66]: v = 4'(c - 8'h61 + 8'd10);
      default:       v = 4'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_val(hi), hex_val(lo)};
  endfunction

  function automatic head_t decide(input logic [WIN_N-1:0][7:0] w, input logic [2:0] m,
                                   input logic fin);
    head_t r;
    logic  uesc;
    r.used = 3'd1;
    r.two  = 1'b0;
    r.b0   = w[0];
    r.b1   = hex_pair(w[4], w[5]);
    uesc   = (w[1] == CH_LOW_U) || (w[1] == CH_UP_U);
    if (w[0] == CH_PLUS) begin
      r.b0 = CH_SPACE;
    end else if (w[0] == CH_PCT) begin
      if (m < 3'd2) begin
        if (!fin) r.used = 3'd0;
      end else if (uesc) begin
        if (m < 3'd6 && !fin) begin
          r.used = 3'd0;
        end else if (m >= 3'd6 && is_hex(w[2]) && is_hex(w[3]) && is_hex(w[4]) &&
                     is_hex(w[5])) begin
          r.b0   = hex_pair(w[2], w[3]);
          r.two  = 1'b1;
          r.used = 3'd6;
        end else if (m >= 3'd4 && is_hex(w[2]) && is_hex(w[3])) begin
          r.b0   = hex_pair(w[2], w[3]);
          r.used = 3'd4;
        end
      end else begin
        if (m < 3'd3 && !fin) begin
          r.used = 3'd0;
        end else if (m >= 3'd3 && is_hex(w[1]) && is_hex(w[2])) begin
          r.b0   = hex_pair(w[1], w[2]);
          r.used = 3'd3;
        end
      end
    end
    return r;
  endfunction

  logic [2:0]                        hc;
  logic [2:0]                        n;
  logic [WIN_N-1:0][7:0]             win;
  logic [2*WIN_N-1:0][7:0]           win_ext;
  logic [WIN_N-1:0][WIN_N-1:0][7:0]  wp;
  head_t                             hd [WIN_N];

  assign hc      = (held_cnt > 3'(HELD_N)) ? 3'(HELD_N) : held_cnt;
  assign n       = hc + 3'd1;
  assign win_ext = {{WIN_N{8'h00}}, win};

  always_comb begin
    win = '0;
    for (int j = 0; j < HELD_N; j++) begin
      if (3'(j) < hc) win[j] = held[j];
    end
    win[hc] = req.in_byte;
  end

  always_comb begin
    for (int p = 0; p < WIN_N; p++) begin
      for (int j = 0; j < WIN_N; j++) begin
        wp[p][j] = win_ext[p+j];
      end
      hd[p] = decide(wp[p], n - 3'(p), req.msg_end);
    end
  end

  always_comb begin
    logic [2:0]            pos;
    logic [2:0]            k;
    logic                  stop;
    logic [WIN_N-1:0][7:0] bytes;
    head_t                 cur;
    pos   = 3'd0;
    k     = 3'd0;
    stop  = 1'b0;
    bytes = '0;
    cur   = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (!stop && pos < n) begin
        cur = hd[pos];
        if (cur.used == 3'd0) begin
          stop = 1'b1;
        end else begin
          bytes[k] = cur.b0;
          k        = k + 3'd1;
          if (cur.two) begin
            bytes[k] = cur.b1;
            k        = k + 3'd1;
          end
          pos = pos + cur.used;
        end
      end
    end
    res.cnt      = k;
    res.bytes    = bytes;
    res.held_cnt = n - pos;
    for (int j = 0; j < HELD_N; j++) begin
      res.held[j] = win_ext[4'(pos) + 4'(j)];
    end
  end

endmodule

`default_nettype wire

// ===== sv/upd_obuf.sv =====
// Result buffer: holds one request's decoded bytes; drains one per cycle if not stalled.
`default_nettype none

module upd_obuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  upd_pkg::ob_load_t load_req,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output upd_pkg::out_t     out_data
);
  import upd_pkg::*;

  logic [WIN_N-1:0][7:0] byte_r, byte_nxt;
  logic [2:0]            cnt_r, cnt_nxt;
  logic                  fin_r, fin_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign free      = (cnt_r == 3'd0) || (cnt_r == 3'd1 && pop);

  assign out_data.out_byte = byte_r[0];
  assign out_data.run_last = (cnt_r == 3'd1);
  assign out_data.msg_last = (cnt_r == 3'd1) && fin_r;

  always_comb begin
    byte_nxt = byte_r;
    cnt_nxt  = cnt_r;
    fin_nxt  = fin_r;
    if (load) begin
      byte_nxt = load_req.bytes;
      cnt_nxt  = load_req.cnt;
      fin_nxt  = load_req.fin;
    end else if (pop) begin
      byte_nxt = byte_r >> 8;
      cnt_nxt  = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    fin_r  <= fin_nxt;
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == 3'd0) || (cnt_r == 3'd1 && !out_stall))
    else $error("result buffer loaded while results remain");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(WIN_N))
    else $error("result count out of range");

endmodule

`default_nettype wire

// ===== sv/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
//
//   channel   direction  handshake             payload
//   in_       in         in_valid / in_stall   upd_pkg::in_t  {in_byte, msg_end}
//   out_      out        out_valid / out_stall upd_pkg::out_t {out_byte, run_last, msg_last}
//
// One byte per cycle is taken while in_stall is low; each byte passes the input register,
// then is decoded into the result buffer, which drives out_.
// The result buffer drains one byte per cycle while out_stall is low; a request that
// yields several bytes holds the input register, and so stalls the input, until the
// buffer is free, as its last byte is taken.
// Reset clears the valid flags and the lookahead count; held bytes need no reset.
// out_stall reaches in_stall in the same cycle through the buffer's free flag.
`default_nettype none

module url_percent_decoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  upd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output upd_pkg::out_t out_data
);
  import upd_pkg::*;

  logic                   in_v_r, in_v_nxt;
  in_t                    in_q_r;
  logic [HELD_N-1:0][7:0] held_r, held_nxt;
  logic [2:0]             held_cnt_r, held_cnt_nxt;
  dec_res_t               dec;
  ob_load_t               ob_req;
  logic                   ob_free;
  logic                   fire;
  logic                   accept;

  upd_decode u_decode (
    .held     (held_r),
    .held_cnt (held_cnt_r),
    .req      (in_q_r),
    .res      (dec)
  );

  assign ob_req.cnt   = dec.cnt;
  assign ob_req.bytes = dec.bytes;
  assign ob_req.fin   = in_q_r.msg_end;

  upd_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .load_req  (ob_req),
    .free      (ob_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign fire     = in_v_r && ob_free;
  assign in_stall = in_v_r && !ob_free;
  assign accept   = in_valid && !in_stall;

  assign in_v_nxt     = accept ? 1'b1 : (fire ? 1'b0 : in_v_r);
  assign held_nxt     = fire ? dec.held : held_r;
  assign held_cnt_nxt = fire ? dec.held_cnt : held_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      held_cnt_r <= 3'd0;
    end else begin
      in_v_r     <= in_v_nxt;
      held_cnt_r <= held_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q_r <= in_data;
    end
    held_r <= held_nxt;
  end

  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r <= 3'(HELD_N))
    else $error("lookahead count out of range");

  a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_q_r.msg_end |=> held_cnt_r == 3'd0)
    else $error("message end left bytes held");

  a_held_head_pct: assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 3'd0 |-> held_r[0] == CH_PCT)
    else $error("held lookahead does not start with an escape");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r && out_valid)
    else $error("input stalled with nothing pending");

endmodule

`default_nettype wire

// ===== tb/sv/upd_checker.sv =====
`timescale 1ns / 100ps
// Checker for the URL percent decoder: predicts each request's decoded bytes and compares them.
module upd_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  upd_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  upd_pkg::out_t out_data,
  output int            fail_count,
  output int            outstanding
);
  import upd_pkg::*;

  logic [HELD_N-1:0][7:0] held_bytes;
  int                     held_count;
  out_t                   decoded_q[$];

  function automatic bit is_hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    return 4'(c - "a" + 10);
  endfunction

  // Resolve the escape at window position p with m bytes available; 0 means wait.
  function automatic int decide_head(input logic [WIN_N-1:0][7:0] w, input int p, input int m,
                                     input bit fin, output int nd, output logic [7:0] d0,
                                     output logic [7:0] d1);
    logic [7:0] c;
    c  = w[p];
    nd = 1;
    d1 = '0;
    if (c == CH_PLUS) begin
      d0 = CH_SPACE;
      return 1;
    end
    if (c != CH_PCT) begin
      d0 = c;
      return 1;
    end
    d0 = CH_PCT;
    if (m < 2) return fin ? 1 : 0;
    if (w[p+1] == CH_LOW_U || w[p+1] == CH_UP_U) begin
      if (m < 6 && !fin) return 0;
      if (m >= 6 && is_hex_digit(w[p+2]) && is_hex_digit(w[p+3]) &&
          is_hex_digit(w[p+4]) && is_hex_digit(w[p+5])) begin
        d0 = {nibble_of(w[p+2]), nibble_of(w[p+3])};
        d1 = {nibble_of(w[p+4]), nibble_of(w[p+5])};
        nd = 2;
        return 6;
      end
      if (m >= 4 && is_hex_digit(w[p+2]) && is_hex_digit(w[p+3])) begin
        d0 = {nibble_of(w[p+2]), nibble_of(w[p+3])};
        return 4;
      end
      return 1;
    end
    if (m < 3 && !fin) return 0;
    if (m >= 3 && is_hex_digit(w[p+1]) && is_hex_digit(w[p+2])) begin
      d0 = {nibble_of(w[p+1]), nibble_of(w[p+2])};
      return 3;
    end
    return 1;
  endfunction

  task automatic decode_request(input in_t req);
    logic [WIN_N-1:0][7:0] win;
    logic [WIN_N-1:0][7:0] dec;
    logic [7:0]            d0;
    logic [7:0]            d1;
    int                    n;
    int                    pos;
    int                    k;
    int                    used;
    int                    nd;
    int                    i;
    bit                    waiting;
    out_t                  r;
    win = '0;
    dec = '0;
    n   = (held_count > HELD_N) ? HELD_N : held_count;
    for (i = 0; i < n; i++) win[i] = held_bytes[i];
    win[n] = req.in_byte;
    n++;
    pos     = 0;
    k       = 0;
    waiting = 0;
    while (pos < n && !waiting) begin
      used = decide_head(win, pos, n - pos, req.msg_end, nd, d0, d1);
      if (used == 0) begin
        waiting = 1;
      end else begin
        if (k < WIN_N) dec[k] = d0;
        k++;
        if (nd == 2) begin
          if (k < WIN_N) dec[k] = d1;
          k++;
        end
        pos += used;
      end
    end
    held_count = 0;
    for (i = pos; i < n && held_count < HELD_N; i++) begin
      held_bytes[held_count] = win[i];
      held_count++;
    end
    for (i = 0; i < k && i < WIN_N; i++) begin
      r.out_byte = dec[i];
      r.run_last = (i == k - 1);
      r.msg_last = (i == k - 1) && req.msg_end;
      decoded_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      held_count  = 0;
      held_bytes  = '0;
      fail_count  = 0;
      outstanding = 0;
      decoded_q.delete();
    end else begin
      if (in_valid && !in_stall) decode_request(in_data);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result byte=%h run_last=%b msg_last=%b", $time,
                     out_data.out_byte, out_data.run_last, out_data.msg_last);
        end else begin
          want = decoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last ||
              out_data.msg_last !== want.msg_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch expected %h/%b/%b got %h/%b/%b",
                       $time, want.out_byte, want.run_last, want.msg_last,
                       out_data.out_byte, out_data.run_last, out_data.msg_last);
          end
        end
      end
      outstanding = decoded_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_url_percent_decoder.sv =====
`timescale 1ns / 100ps
// Top of the URL percent decoder testbench: clock, reset, stimulus and verdict.
module tb_url_percent_decoder;
  import upd_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_t        in_data;
  logic       out_valid;
  logic       out_stall;
  out_t       out_data;
  int         fail_count;
  int         outstanding;
  int         bytes_sent;
  int         msg_count;
  int         hold_left;
  int         free_left;
  logic [7:0] msg_q[$];

  url_percent_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  upd_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'("0" + v);
    if ($urandom_range(0, 1) == 1) return 8'("a" + v - 10);
    return 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] rand_u();
    return ($urandom_range(0, 1) == 1) ? CH_LOW_U : CH_UP_U;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit last, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid         = 1'b1;
    in_data.in_byte  = b;
    in_data.msg_end  = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input bit gaps);
    int i;
    for (i = 0; i < msg_q.size(); i++) send_byte(msg_q[i], i == msg_q.size() - 1, gaps);
    msg_q.delete();
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) msg_q.push_back(s[i]);
    send_message(1'b1);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic add_token();
    int r;
    r = $urandom_range(0, 99);
    if (r < 18) begin
      msg_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (r < 28) begin
      msg_q.push_back(CH_PLUS);
    end else if (r < 48) begin
      msg_q.push_back(CH_PCT);
      msg_q.push_back(rand_hex());
      msg_q.push_back(rand_hex());
    end else if (r < 62) begin
      msg_q.push_back(CH_PCT);
      msg_q.push_back(rand_u());
      repeat (4) msg_q.push_back(rand_hex());
    end else if (r < 70) begin
      msg_q.push_back(CH_PCT);
      msg_q.push_back(rand_u());
      repeat (2) msg_q.push_back(rand_hex());
      if ($urandom_range(0, 1) == 1) msg_q.push_back(rand_non_hex());
    end else if (r < 78) begin
      msg_q.push_back(CH_PCT);
      if ($urandom_range(0, 1) == 1) msg_q.push_back(rand_hex());
      msg_q.push_back(rand_non_hex());
    end else if (r < 84) begin
      msg_q.push_back(CH_PCT);
      msg_q.push_back(rand_u());
      repeat ($urandom_range(0, 3)) msg_q.push_back(rand_hex());
      msg_q.push_back(rand_non_hex());
    end else if (r < 92) begin
      msg_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      msg_q.push_back(CH_PCT);
      msg_q.push_back(($urandom_range(0, 1) == 1) ? CH_PCT : rand_u());
    end
  endtask

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    free_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (free_left > 0) begin
        out_stall = 1'b0;
        free_left--;
      end else begin
        out_stall = 1'b0;
        free_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 8);
        hold_left = gap_len();
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    bytes_sent = 0;
    msg_count  = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    send_text("+");
    send_text("%4a");
    send_text("%U00fF");
    send_text("%uAB");
    send_text("%g1");
    send_text("%");
    send_text("%u");
    msg_q.push_back(8'h00);
    send_message(1'b1);
    msg_q.push_back(8'hFF);
    send_message(1'b1);
    wait_drained();

    while (bytes_sent < 470) begin
      repeat ($urandom_range(1, 6)) add_token();
      send_message($urandom_range(0, 9) < 7);
      msg_count++;
      if (msg_count % 20 == 0) wait_drained();
    end
    wait_drained();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/upd_pkg.sv
sv/upd_decode.sv
sv/upd_obuf.sv
sv/url_percent_decoder.sv
tb/sv/upd_checker.sv
tb/sv/tb_url_percent_decoder.sv
